@@ rtl/core/wbs_pkg.sv @@
// Shared constants, types and helpers for the waypoint bearing steering block.
package wbs_pkg;

  localparam int CordicSteps = 24;
  localparam int AngW        = 32;
  localparam int CoordW      = 32;
  localparam int TrigW       = 34;
  localparam int VecW        = 36;

  localparam logic signed [AngW-1:0] Deg90  = 32'sd377487360;
  localparam logic signed [AngW-1:0] Deg180 = 32'sd754974720;
  localparam logic signed [AngW-1:0] Deg360 = 32'sd1509949440;
  localparam logic signed [TrigW-1:0] CordicK = 34'sd652032874;
  localparam logic [25:0] CmPerLsbQ24 = 26'd44477971;

  localparam logic [29:0] BearThrRst = 30'd20971520;
  localparam logic [23:0] DistThrRst = 24'd100;

  localparam logic [0:0] RegBearThr = 1'b0;
  localparam logic [0:0] RegDistThr = 1'b1;

  typedef enum logic [1:0] {
    ActHold  = 2'd0,
    ActLeft  = 2'd1,
    ActRight = 2'd2,
    ActFwd   = 2'd3
  } action_e;

  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 32'sd188743680;  1: t = 32'sd111421900;  2: t = 32'sd58872272;
      3: t = 32'sd29884485;   4: t = 32'sd15000234;   5: t = 32'sd7507429;
      6: t = 32'sd3754631;    7: t = 32'sd1877430;    8: t = 32'sd938729;
      9: t = 32'sd469366;     10: t = 32'sd234683;    11: t = 32'sd117342;
      12: t = 32'sd58671;     13: t = 32'sd29335;     14: t = 32'sd14668;
      15: t = 32'sd7334;      16: t = 32'sd3667;      17: t = 32'sd1833;
      18: t = 32'sd917;       19: t = 32'sd458;       20: t = 32'sd229;
      21: t = 32'sd115;       22: t = 32'sd57;        23: t = 32'sd29;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Stage-carried payload of one item.
  typedef struct packed {
    logic signed [CoordW-1:0] lat1;
    logic signed [CoordW-1:0] lon1;
    logic signed [CoordW-1:0] lat2;
    logic signed [CoordW-1:0] lon2;
    logic signed [CoordW-1:0] head;
  } fix_t;

endpackage

@@ rtl/core/wbs_rot_cell.sv @@
// One CORDIC rotation step for sin/cos, one register stage.
module wbs_rot_cell #(
  parameter int Step = 0
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [wbs_pkg::TrigW-1:0]    x_i,
  input  logic signed [wbs_pkg::TrigW-1:0]    y_i,
  input  logic signed [wbs_pkg::AngW-1:0]     z_i,
  output logic signed [wbs_pkg::TrigW-1:0]    x_o,
  output logic signed [wbs_pkg::TrigW-1:0]    y_o,
  output logic signed [wbs_pkg::AngW-1:0]     z_o
);
  import wbs_pkg::*;
  logic signed [TrigW-1:0] x_q, y_q, x_d, y_d;
  logic signed [AngW-1:0]  z_q, z_d;

  always_comb begin
    if (!z_i[AngW-1]) begin
      x_d = x_i - (y_i >>> Step);
      y_d = y_i + (x_i >>> Step);
      z_d = z_i - atan_tab(Step);
    end else begin
      x_d = x_i + (y_i >>> Step);
      y_d = y_i - (x_i >>> Step);
      z_d = z_i + atan_tab(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

@@ rtl/core/wbs_vec_cell.sv @@
// One CORDIC vectoring step for atan2, one register stage.
module wbs_vec_cell #(
  parameter int Step = 0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [wbs_pkg::VecW-1:0]  x_i,
  input  logic signed [wbs_pkg::VecW-1:0]  y_i,
  input  logic signed [wbs_pkg::AngW-1:0]  z_i,
  output logic signed [wbs_pkg::VecW-1:0]  x_o,
  output logic signed [wbs_pkg::VecW-1:0]  y_o,
  output logic signed [wbs_pkg::AngW-1:0]  z_o
);
  import wbs_pkg::*;
  logic signed [VecW-1:0] x_q, y_q, x_d, y_d;
  logic signed [AngW-1:0] z_q, z_d;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + (y_i >>> Step);
      y_d = y_i - (x_i >>> Step);
      z_d = z_i + atan_tab(Step);
    end else begin
      x_d = x_i - (y_i >>> Step);
      y_d = y_i + (x_i >>> Step);
      z_d = z_i - atan_tab(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

@@ rtl/core/wbs_sqrt_cell.sv @@
// One restoring square-root step (one result bit), one register stage.
module wbs_sqrt_cell #(
  parameter int Step = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] res_i,
  output logic [63:0] rem_o,
  output logic [63:0] res_o
);
  logic [63:0] rem_q, rem_d, one, trial;
  logic [63:0] res_q, res_d;

  always_comb begin
    one   = 64'd1 << (2 * (31 - Step));
    trial = res_i + one;
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      res_d = (res_i >> 1) + one;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign rem_o = rem_q;
  assign res_o = res_q;
endmodule

@@ rtl/core/waypoint_bearing_steer_top.sv @@
// Top level of the waypoint bearing steering block.
//
//  channel | dir | tdata fields (low bit up)                              | tuser
//  s_axis  | in  | cur_lat 30, cur_lon 31, dest_lat 30, dest_lon 31, hd 31 | -
//  m_axis  | out | bearing 31, bearing_error 32, distance_cm 32            | action 2
//  cfg     | in  | cfg_idx_i selects register, cfg_data_i carries value    | -
//
// One item enters every cycle unless the output is stalled. The stages are
// range reduction, 24 rotation cells per angle for sin/cos, product stages,
// the atan2 operand stage, 24 vectoring cells for atan2, the square-forming
// stages, 32 square root cells, a final scaling stage and the output register.
// The whole chain advances together when the output register is empty or being
// taken, so a stall freezes it and drops s_axis_tready in the same cycle.
// Reset clears valid bits and restores threshold registers.
module waypoint_bearing_steer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [159:0]  s_axis_tdata,   // cur_lat, cur_lon, dest_lat, dest_lon, heading
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,   // bearing, bearing_error, distance_cm
  output logic [1:0]    m_axis_tuser,   // action
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  import wbs_pkg::*;

  localparam int NS = CordicSteps;
  // Stage map: 0 reduce, 1..NS rotate, then products, vectoring, squares, sqrt, scaling.
  localparam int PR  = NS + 1;      // fix stage aligned with product stage 1
  localparam int LAT = 1 + NS + 3 + NS + 2 + 32 + 1;

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o = 1'b1;

  // Thresholds.
  logic [29:0] bthr_q;
  logic [23:0] dthr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bthr_q <= BearThrRst;
      dthr_q <= DistThrRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegBearThr: bthr_q <= cfg_data_i[29:0];
        RegDistThr: dthr_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
  end

  // Unpack input fields, sign extended.
  fix_t fin;
  always_comb begin
    fin.lat1 = CoordW'(signed'(s_axis_tdata[29:0]));
    fin.lon1 = CoordW'(signed'(s_axis_tdata[60:30]));
    fin.lat2 = CoordW'(signed'(s_axis_tdata[90:61]));
    fin.lon2 = CoordW'(signed'(s_axis_tdata[121:91]));
    fin.head = CoordW'(signed'(s_axis_tdata[152:122]));
  end

  // Range reduction of an angle to [-90,90] with a negate flag.
  function automatic logic [AngW:0] reduce(input logic signed [33:0] a);
    logic signed [33:0] r;
    logic neg;
    r = a;
    neg = 1'b0;
    // inputs stay within +-2 turns, so two corrections suffice
    if (r >= 34'(Deg180)) r = r - 34'(Deg360);
    if (r >= 34'(Deg180)) r = r - 34'(Deg360);
    if (r < -34'(Deg180)) r = r + 34'(Deg360);
    if (r < -34'(Deg180)) r = r + 34'(Deg360);
    if (r > 34'(Deg90)) begin r = r - 34'(Deg180); neg = 1'b1; end
    else if (r < -34'(Deg90)) begin r = r + 34'(Deg180); neg = 1'b1; end
    return {neg, r[AngW-1:0]};
  endfunction

  // Stage 0: reduce four angles; carry the fix.
  localparam int NA = 4; // lat1, lat2, dlon, mid latitude
  logic [AngW:0] red_d [NA];
  logic [AngW:0] red_q [NA];
  fix_t fix_q [LAT];
  logic signed [33:0] dlon_raw, mid_raw;
  always_comb begin
    dlon_raw = 34'(fin.lon2) - 34'(fin.lon1);
    mid_raw  = (34'(fin.lat1) + 34'(fin.lat2)) >>> 1;
    red_d[0] = reduce(34'(fin.lat1));
    red_d[1] = reduce(34'(fin.lat2));
    red_d[2] = reduce(dlon_raw);
    red_d[3] = reduce(mid_raw);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red_d;
      fix_q[0] <= fin;
    end
  end
  for (genvar k = 1; k < LAT; k++) begin : g_fix
    always_ff @(posedge clk_i) if (adv) fix_q[k] <= fix_q[k-1];
  end

  // Rotation chains for the four angles.
  logic signed [TrigW-1:0] rx [NA][NS+1];
  logic signed [TrigW-1:0] ry [NA][NS+1];
  logic signed [AngW-1:0]  rz [NA][NS+1];
  logic                    neg_q [NA][NS+1];
  for (genvar a = 0; a < NA; a++) begin : g_ang
    assign rx[a][0] = CordicK;
    assign ry[a][0] = '0;
    assign rz[a][0] = red_q[a][AngW-1:0];
    assign neg_q[a][0] = red_q[a][AngW];
    for (genvar s = 0; s < NS; s++) begin : g_rot
      wbs_rot_cell #(.Step(s)) u_rot (
        .clk_i, .en_i(adv),
        .x_i(rx[a][s]), .y_i(ry[a][s]), .z_i(rz[a][s]),
        .x_o(rx[a][s+1]), .y_o(ry[a][s+1]), .z_o(rz[a][s+1])
      );
      always_ff @(posedge clk_i) if (adv) neg_q[a][s+1] <= neg_q[a][s];
    end
  end

  logic signed [TrigW-1:0] s1, c1, s2, c2, sd, cd, cm;
  assign s1 = neg_q[0][NS] ? -ry[0][NS] : ry[0][NS];
  assign c1 = neg_q[0][NS] ? -rx[0][NS] : rx[0][NS];
  assign s2 = neg_q[1][NS] ? -ry[1][NS] : ry[1][NS];
  assign c2 = neg_q[1][NS] ? -rx[1][NS] : rx[1][NS];
  assign sd = neg_q[2][NS] ? -ry[2][NS] : ry[2][NS];
  assign cd = neg_q[2][NS] ? -rx[2][NS] : rx[2][NS];
  assign cm = neg_q[3][NS] ? -rx[3][NS] : rx[3][NS];

  // Product stage 1.
  logic signed [TrigW-1:0] y_p1, a_p1, b_p1, cd_p1, cm_p1;
  logic signed [67:0] m_sdc2, m_c1s2, m_s1c2;
  assign m_sdc2 = 68'(sd) * 68'(c2);
  assign m_c1s2 = 68'(c1) * 68'(s2);
  assign m_s1c2 = 68'(s1) * 68'(c2);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_p1  <= TrigW'(m_sdc2 >>> 30);
      a_p1  <= TrigW'(m_c1s2 >>> 30);
      b_p1  <= TrigW'(m_s1c2 >>> 30);
      cd_p1 <= cd;
      cm_p1 <= cm[TrigW-1] ? -cm : cm;
    end
  end

  // Product stage 2: second product, distance cos product.
  logic signed [TrigW-1:0] y_p2, a_p2, e_p2;
  logic signed [67:0] m_bcd;
  logic [32:0] dlon_abs;
  logic [65:0] m_lon;
  logic [33:0] blon_p2;
  logic signed [33:0] dlo;
  always_comb begin
    dlo = 34'(fix_q[PR].lon2) - 34'(fix_q[PR].lon1);
    dlon_abs = dlo[33] ? 33'(-dlo) : dlo[32:0];
    m_bcd = 68'(b_p1) * 68'(cd_p1);
    m_lon = 66'(dlon_abs) * 66'(cm_p1[32:0]);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_p2 <= y_p1;
      a_p2 <= a_p1;
      e_p2 <= TrigW'(m_bcd >>> 30);
      blon_p2 <= m_lon[65:30] > 36'h80000000 ? 34'h80000000 : 34'(m_lon[65:30]);
    end
  end

  // Stage 3: atan2 operands and pre-rotation.
  logic signed [VecW-1:0] vy, vx, vx0, vy0;
  logic signed [AngW-1:0] vz0;
  logic                   zero_d;
  always_comb begin
    vy = VecW'(y_p2);
    vx = VecW'(a_p2) - VecW'(e_p2);
    zero_d = (vx == 0) && (vy == 0);
    if (vx < 0) begin
      vz0 = (vy >= 0) ? Deg180 : -Deg180;
      vx0 = -vx; vy0 = -vy;
    end else begin
      vz0 = '0; vx0 = vx; vy0 = vy;
    end
  end

  logic signed [VecW-1:0] vxs [NS+1];
  logic signed [VecW-1:0] vys [NS+1];
  logic signed [AngW-1:0] vzs [NS+1];
  logic                   zr [NS+1];
  logic [33:0]            bl [NS+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vxs[0] <= vx0; vys[0] <= vy0; vzs[0] <= vz0;
      zr[0] <= zero_d; bl[0] <= blon_p2;
    end
  end
  for (genvar s = 0; s < NS; s++) begin : g_vec
    wbs_vec_cell #(.Step(s)) u_vec (
      .clk_i, .en_i(adv),
      .x_i(vxs[s]), .y_i(vys[s]), .z_i(vzs[s]),
      .x_o(vxs[s+1]), .y_o(vys[s+1]), .z_o(vzs[s+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        zr[s+1] <= zr[s];
        bl[s+1] <= bl[s];
      end
    end
  end

  // Clamp bearing, form squares.
  localparam int PS = PR + 2 + NS;  // fix stage aligned with vectoring end
  logic signed [AngW-1:0] bear_c, bear_q;
  logic [63:0] sq_q;
  logic signed [33:0] dl;
  logic [33:0] dla_c;
  logic [67:0] m_la, m_lo;
  always_comb begin
    bear_c = vzs[NS];
    if (bear_c > Deg180) bear_c = Deg180;
    if (bear_c < -Deg180) bear_c = -Deg180;
    if (zr[NS]) bear_c = '0;
    dl = 34'(fix_q[PS].lat2) - 34'(fix_q[PS].lat1);
    dla_c = dl[33] ? -dl : dl;
    if (dla_c > 34'h80000000) dla_c = 34'h80000000;
    m_la = 68'(dla_c) * 68'(dla_c);
    m_lo = 68'(bl[NS]) * 68'(bl[NS]);
  end
  logic [63:0] la_q, lo_q;
  logic signed [AngW-1:0] bear0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      la_q <= m_la[63:0];
      lo_q <= m_lo[63:0];
      bear0_q <= bear_c;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= la_q + lo_q;
      bear_q <= bear0_q;
    end
  end

  // Square root chain.
  logic [63:0] rem [33];
  logic [63:0] res [33];
  logic signed [AngW-1:0] bs [33];
  assign rem[0] = sq_q;
  assign res[0] = '0;
  assign bs[0]  = bear_q;
  for (genvar s = 0; s < 32; s++) begin : g_sq
    wbs_sqrt_cell #(.Step(s)) u_sq (
      .clk_i, .en_i(adv),
      .rem_i(rem[s]), .res_i(res[s]), .rem_o(rem[s+1]), .res_o(res[s+1])
    );
    always_ff @(posedge clk_i) if (adv) bs[s+1] <= bs[s];
  end

  // Scale to centimetres; the root of a 64-bit sum fits in 32 bits.
  logic [58:0] m_cm;
  logic [31:0] dist_q;
  logic signed [AngW-1:0] bearf_q;
  assign m_cm = 59'(res[32][31:0]) * 59'(CmPerLsbQ24);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q  <= (m_cm[58:24] > 35'hFFFFFFFF) ? 32'hFFFFFFFF : m_cm[55:24];
      bearf_q <= bs[32];
    end
  end

  // Error, decision and output register.
  localparam int PF = LAT - 1;
  logic signed [AngW:0] err;
  logic [AngW:0] aerr;
  action_e act;
  always_comb begin
    err  = 33'(bearf_q) - 33'(fix_q[PF].head);
    aerr = err[AngW] ? -err : err;
    if (aerr > 33'(bthr_q)) act = err[AngW] ? ActRight : ActLeft;
    else if (dist_q <= 32'(dthr_q)) act = ActHold;
    else act = ActFwd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vld_q[LAT-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {1'b0, dist_q, err[31:0], bearf_q[30:0]};
      m_axis_tuser <= act;
    end
  end
endmodule

@@ rtl/core/wbs_checker.sv @@
// Port-level assertions for the waypoint bearing steering block, with bind.
module wbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[95])
    else $error("pad bit set");
  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'd1 |-> !m_axis_tdata[62])
    else $error("left turn with negative error");
endmodule

bind waypoint_bearing_steer_top wbs_checker u_wbs_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
